// ----- hw/rtl/disparity_to_point_reprojection_unit_assert.svh -----
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_unit_assert
// Assertion macros for the reprojection unit.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH

// antecedent implies consequent on the same edge
`define DPR_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// antecedent implies consequent on the next edge
`define DPR_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/dpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_pkg
// Types and constants shared by the reprojection unit.
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int MaxColsDefault = 1024;
  localparam int MaxRowsDefault = 1024;
  localparam int DispMinRaw     = 48;
  localparam int NumRegs        = 8;
  localparam int AddrW          = 6;
  localparam int AccW           = 50;
  localparam int NumW           = 32;   // low bits of |acc| << 16 fed bit by bit
  localparam int QuoW           = 32;   // quotient bits kept (above saturates)

  localparam logic [31:0] PosLimit = 32'h7fff_ffff;
  localparam logic [31:0] NegLimit = 32'h8000_0000;

  typedef struct packed {
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
    logic signed [15:0] disparity;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               saturated;
  } point_t;

endpackage

// ----- hw/rtl/dpr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Produces saturated signed Q16.16 quotients.
// ----------------------------------------------------------------------------
module dpr_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [2:0][dpr_pkg::AccW-1:0] num,  // signed numerators
  input  logic [dpr_pkg::AccW-1:0]    den,    // signed divisor
  input  logic [23:0]                 rgb,
  output logic                        out_valid,
  output dpr_pkg::point_t             result
);

  localparam int NW = dpr_pkg::NumW;
  localparam int QW = dpr_pkg::QuoW;
  localparam int RW = dpr_pkg::AccW + 1;
  localparam int S  = QW + 1;   // stage 0 is the load stage

  // The numerator is |num| << 16. Its bits above 31 (|num| >> 16) preload the
  // remainder; if that is already >= divisor the quotient is >= 2^32 and
  // saturates. Otherwise the 32 low bits give the 32 quotient bits.
  logic [S-1:0]                    vld;
  logic [S-1:0][dpr_pkg::AccW-1:0] dmag;
  logic [S-1:0]                    dzero;
  logic [S-1:0][2:0]               numneg;
  logic [S-1:0][2:0]               numzero;
  logic [S-1:0][2:0]               qneg;
  logic [S-1:0][2:0][NW-1:0]       nreg;
  logic [S-1:0][2:0][RW-1:0]       rem;
  logic [S-1:0][2:0][QW-1:0]       quo;
  logic [S-1:0][23:0]              col;

  logic [dpr_pkg::AccW-1:0] den_mag;
  assign den_mag = den[dpr_pkg::AccW-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[S-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag[0]  <= den_mag;
      dzero[0] <= (den == '0);
      col[0]   <= rgb;
      for (int l = 0; l < 3; l++) begin
        logic [dpr_pkg::AccW-1:0] m;
        m = num[l][dpr_pkg::AccW-1] ? (~num[l] + 1'b1) : num[l];
        numneg[0][l]  <= num[l][dpr_pkg::AccW-1];
        numzero[0][l] <= (num[l] == '0);
        qneg[0][l]    <= num[l][dpr_pkg::AccW-1] ^ den[dpr_pkg::AccW-1];
        nreg[0][l]    <= {m[15:0], 16'b0};
        rem[0][l]     <= RW'(m[dpr_pkg::AccW-1:16]);
        quo[0][l]     <= '0;
      end
      for (int s = 1; s < S; s++) begin
        dmag[s]  <= dmag[s-1];
        dzero[s] <= dzero[s-1];
        col[s]   <= col[s-1];
        numneg[s]  <= numneg[s-1];
        numzero[s] <= numzero[s-1];
        qneg[s]    <= qneg[s-1];
        for (int l = 0; l < 3; l++) begin
          logic [dpr_pkg::AccW+1:0] tr;
          logic [dpr_pkg::AccW+1:0] df;
          // quotient bit (QW-s): bring in the next numerator bit
          tr = {rem[s-1][l], nreg[s-1][l][NW-1]};
          df = tr - {2'b0, dmag[s-1]};
          nreg[s][l] <= {nreg[s-1][l][NW-2:0], 1'b0};
          if (!df[dpr_pkg::AccW+1]) begin
            rem[s][l] <= df[dpr_pkg::AccW:0];
            quo[s][l] <= {quo[s-1][l][QW-2:0], 1'b1};
          end else begin
            rem[s][l] <= tr[dpr_pkg::AccW:0];
            quo[s][l] <= {quo[s-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // quotient >= 2^32 when the preloaded remainder is not below the divisor
  logic [S-1:1][2:0] hi_ovf;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        hi_ovf[1][l] <= (rem[0][l] >= {1'b0, dmag[0]});
      end
      for (int s = 2; s < S; s++) begin
        hi_ovf[s] <= hi_ovf[s-1];
      end
    end
  end

  // Final formatting (combinational, from the last stage)
  logic [2:0][31:0] coord;
  logic [2:0]       lsat;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [QW-1:0] q;
      q = quo[S-1][l];
      lsat[l]  = 1'b0;
      coord[l] = '0;
      if (dzero[S-1]) begin
        lsat[l]  = 1'b1;
        coord[l] = numzero[S-1][l] ? 32'd0 :
                   (numneg[S-1][l] ? dpr_pkg::NegLimit : dpr_pkg::PosLimit);
      end else if (qneg[S-1][l]) begin
        if (hi_ovf[S-1][l] || q > QW'(dpr_pkg::NegLimit)) begin
          lsat[l]  = 1'b1;
          coord[l] = dpr_pkg::NegLimit;
        end else begin
          coord[l] = 32'(~q + 1'b1);
        end
      end else begin
        if (hi_ovf[S-1][l] || q > QW'(dpr_pkg::PosLimit)) begin
          lsat[l]  = 1'b1;
          coord[l] = dpr_pkg::PosLimit;
        end else begin
          coord[l] = q[31:0];
        end
      end
    end
  end

  assign out_valid = vld[S-1];
  assign result = '{point_x:   coord[0],
                    point_y:   coord[1],
                    point_z:   coord[2],
                    red_out:   col[S-1][23:16],
                    green_out: col[S-1][15:8],
                    blue_out:  col[S-1][7:0],
                    saturated: dzero[S-1] | (|lsat)};

endmodule

// ----- hw/rtl/disparity_to_point_reprojection_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_unit
// Reprojects disparity pixels to Q16.16 3-D points through a 4x4 matrix.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and returns one point per clock when the
// output is not stalled. Each pixel passes through an operand stage, a product
// stage and a sum stage that form the four homogeneous sums, then a load stage
// and a 32-stage restoring divider (one quotient bit per stage, three lanes)
// and the output register. The whole pipeline holds while a point waits on a
// stalled output. Pixels with disparity below 3.0 or outside MAX_COLS x
// MAX_ROWS are dropped. Matrix registers sit at byte addresses 8*i and must be
// written while idle.
module disparity_to_point_reprojection_unit #(
  parameter int MAX_COLS = dpr_pkg::MaxColsDefault,
  parameter int MAX_ROWS = dpr_pkg::MaxRowsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpr_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dpr_pkg::pixel_t            in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dpr_pkg::point_t            out_data
);

  localparam int AW = dpr_pkg::AccW;

  logic [dpr_pkg::NumRegs-1:0][63:0] q_regs;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign prdata  = q_regs[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_regs <= '0;
    end else if (psel && penable && pwrite) begin
      q_regs[reg_idx] <= pwdata;
    end
  end

  // pipeline advances whenever the output slot is free or being taken
  logic adv;
  logic div_valid;
  dpr_pkg::point_t div_res;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic accept;
  logic keep;
  assign accept = in_valid && adv;
  assign keep = (in_data.disparity >= 16'(dpr_pkg::DispMinRaw))
             && (32'(in_data.pixel_col) < MAX_COLS)
             && (32'(in_data.pixel_row) < MAX_ROWS);

  // stage 1: register operands
  logic s1_v, s2_v, s3_v;
  logic [9:0] s1_col, s1_row;
  logic signed [15:0] s1_d;
  logic [23:0] s1_rgb, s2_rgb, s3_rgb;
  // stage 2: products
  logic signed [3:0][42:0] p0, p1;
  logic signed [3:0][47:0] p2;
  logic signed [3:0][31:0] p3;
  // stage 3: sums
  logic [3:0][AW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (adv) begin
      s1_v <= accept && keep;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col <= in_data.pixel_col;
      s1_row <= in_data.pixel_row;
      s1_d   <= in_data.disparity;
      s1_rgb <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      s2_rgb <= s1_rgb;
      s3_rgb <= s2_rgb;
      for (int r = 0; r < 4; r++) begin
        p0[r] <= $signed(q_regs[2*r][31:0])  * $signed({1'b0, s1_col});
        p1[r] <= $signed(q_regs[2*r][63:32]) * $signed({1'b0, s1_row});
        p2[r] <= $signed(q_regs[2*r+1][31:0]) * s1_d;
        p3[r] <= $signed(q_regs[2*r+1][63:32]);
        acc[r] <= AW'((AW'($signed(p0[r])) + AW'($signed(p1[r]))) <<< 4)
                + AW'($signed(p2[r])) + (AW'($signed(p3[r])) <<< 4);
      end
    end
  end

  dpr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s3_v),
    .num       ({acc[2], acc[1], acc[0]}),
    .den       (acc[3]),
    .rgb       (s3_rgb),
    .out_valid (div_valid),
    .result    (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= div_res;
    end
  end

`include "disparity_to_point_reprojection_unit_assert.svh"

  `DPR_ASSERT_IMP(a_stall_iff_blocked, in_stall, out_valid && out_stall)
  `DPR_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data))
  `DPR_ASSERT_NEXT(a_drop_low_disp, accept && !keep, !s1_v)
  `DPR_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

// ----- bench/disparity_to_point_reprojection_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_unit_tb
// Drives pixel requests through the reprojection unit under several matrix
// settings and compares every emitted point with a local fixed-point predictor.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection_unit_tb;

  localparam int DrainCycles = 120;
  localparam int WatchLimit  = 20000;

  typedef enum logic [5:0] {
    RegRow0A = 6'd0,  RegRow0B = 6'd8,  RegRow1A = 6'd16, RegRow1B = 6'd24,
    RegRow2A = 6'd32, RegRow2B = 6'd40, RegRow3A = 6'd48, RegRow3B = 6'd56
  } reg_addr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dpr_pkg::AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  dpr_pkg::pixel_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dpr_pkg::point_t out_data;

  logic [63:0] matrix_regs [8];
  dpr_pkg::point_t expected_points [$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_gaps = 1'b1;
  bit stall_enable = 1'b1;

  disparity_to_point_reprojection_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (!long_gaps || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [63:0] coef(int r, int c);
    logic [63:0] w;
    w = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? {{32{w[63]}}, w[63:32]} : {{32{w[31]}}, w[31:0]};
  endfunction

  // magnitude division, truncated toward zero, then clamped to Q16.16 range
  function automatic logic [31:0] coord_div(logic signed [63:0] num,
                                            logic signed [63:0] den,
                                            inout logic sat);
    logic [63:0] mn, md;
    logic [79:0] qm;
    if (den == 0) begin
      sat = 1'b1;
      if (num > 0) return dpr_pkg::PosLimit;
      if (num < 0) return dpr_pkg::NegLimit;
      return '0;
    end
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    qm = {mn, 16'h0} / {16'h0, md};
    if ((num < 0) != (den < 0)) begin
      if (qm > 80'h8000_0000) begin
        sat = 1'b1;
        return dpr_pkg::NegLimit;
      end
      return -qm[31:0];
    end
    if (qm > 80'h7fff_ffff) begin
      sat = 1'b1;
      return dpr_pkg::PosLimit;
    end
    return qm[31:0];
  endfunction

  task automatic predict_point(dpr_pkg::pixel_t px);
    logic signed [63:0] acc [4];
    logic signed [63:0] col, row, d;
    logic sat;
    dpr_pkg::point_t pt;
    col = px.pixel_col;
    row = px.pixel_row;
    d = px.disparity;
    if (d < dpr_pkg::DispMinRaw) return;
    for (int r = 0; r < 4; r++)
      acc[r] = (coef(r, 0) * col + coef(r, 1) * row) * 16 + coef(r, 2) * d
             + coef(r, 3) * 16;
    sat = (acc[3] == 0);
    pt.point_x = coord_div(acc[0], acc[3], sat);
    pt.point_y = coord_div(acc[1], acc[3], sat);
    pt.point_z = coord_div(acc[2], acc[3], sat);
    pt.red_out = px.red_in;
    pt.green_out = px.green_in;
    pt.blue_out = px.blue_in;
    pt.saturated = sat;
    expected_points.push_back(pt);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(reg_addr_t addr, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    matrix_regs[addr / 8] = value;
  endtask

  task automatic load_matrix(logic signed [31:0] m [16]);
    for (int r = 0; r < 4; r++) begin
      write_reg(reg_addr_t'(r * 16), {m[r * 4 + 1], m[r * 4]});
      write_reg(reg_addr_t'(r * 16 + 8), {m[r * 4 + 3], m[r * 4 + 2]});
    end
  endtask

  // valid drops only when a gap follows; the caller drops it at the end
  task automatic send_pixel(dpr_pkg::pixel_t px);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    predict_point(px);
  endtask

  // hold until every point has come back, then let dropped pixels flush
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic dpr_pkg::pixel_t rand_pixel(bit mostly_valid);
    dpr_pkg::pixel_t px;
    px.pixel_col = 10'($urandom);
    px.pixel_row = 10'($urandom);
    px.red_in = 8'($urandom);
    px.green_in = 8'($urandom);
    px.blue_in = 8'($urandom);
    if (mostly_valid && $urandom_range(0, 9) < 8)
      px.disparity = 16'($urandom_range(48, 32767));
    else
      px.disparity = 16'($urandom);
    return px;
  endfunction

  // output side: random stall, check each accepted point
  always @(posedge clk) begin
    dpr_pkg::point_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report("unexpected point", out_data.point_x, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_x !== want.point_x) report("x", out_data.point_x, want.point_x);
          if (out_data.point_y !== want.point_y) report("y", out_data.point_y, want.point_y);
          if (out_data.point_z !== want.point_z) report("z", out_data.point_z, want.point_z);
          if (out_data.red_out !== want.red_out) report("red", out_data.red_out, want.red_out);
          if (out_data.green_out !== want.green_out)
            report("green", out_data.green_out, want.green_out);
          if (out_data.blue_out !== want.blue_out)
            report("blue", out_data.blue_out, want.blue_out);
          if (out_data.saturated !== want.saturated)
            report("saturated", out_data.saturated, want.saturated);
        end
      end
      out_stall <= stall_enable && (gap_len() != 0);
    end
  end

  // watchdog: cycles with no request or point accepted and no register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_identity_like();
    logic signed [31:0] m [16];
    dpr_pkg::pixel_t px;
    // X = col/d-ish, typical stereo Q shape
    m = '{32'h0001_0000, 0, 0, -32'sd320 <<< 16,
          0, 32'h0001_0000, 0, -32'sd240 <<< 16,
          0, 0, 0, 32'sd500 <<< 16,
          0, 0, 32'h0000_0100, 0};
    load_matrix(m);
    px = '{10'd0, 10'd0, 16'sd48, 8'h00, 8'hff, 8'h55};     send_pixel(px);
    px = '{10'd1023, 10'd1023, 16'sd32767, 8'hff, 8'h00, 8'haa}; send_pixel(px);
    px = '{10'd5, 10'd5, 16'sd47, 8'h1, 8'h2, 8'h3};        send_pixel(px);
    px = '{10'd5, 10'd5, -16'sd32768, 8'h1, 8'h2, 8'h3};    send_pixel(px);
    px = '{10'd5, 10'd5, -16'sd1, 8'h1, 8'h2, 8'h3};        send_pixel(px);
    px = '{10'd320, 10'd240, 16'sd49, 8'h80, 8'h40, 8'h20}; send_pixel(px);
    px = '{10'h2aa, 10'h155, 16'sh5555, 8'h5a, 8'ha5, 8'hc3}; send_pixel(px);
    px = '{10'h155, 10'h2aa, 16'sh2aaa, 8'ha5, 8'h5a, 8'h3c}; send_pixel(px);
    wait_idle();
  endtask

  task automatic test_zero_divisor();
    logic signed [31:0] m [16];
    // row 3 zero: every valid pixel hits the zero-divisor path, signs vary
    m = '{32'h0001_0000, 0, 0, -32'sd512 <<< 16,
          0, 0, 0, 0,
          0, -32'sd1, 0, 0,
          0, 0, 0, 0};
    load_matrix(m);
    send_pixel('{10'd1000, 10'd3, 16'sd100, 8'd1, 8'd2, 8'd3});
    send_pixel('{10'd12, 10'd3, 16'sd100, 8'd4, 8'd5, 8'd6});
    send_pixel('{10'd512, 10'd0, 16'sd100, 8'd7, 8'd8, 8'd9});
    wait_idle();
  endtask

  task automatic test_extremes();
    logic signed [31:0] m [16];
    // huge numerators over a tiny divisor: quotient overflow both ways
    m = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff,
          0, 0, 32'hffff_ffff, 0};
    load_matrix(m);
    send_pixel('{10'd1023, 10'd1023, 16'sd32767, 8'hff, 8'hff, 8'hff});
    send_pixel('{10'd0, 10'd0, 16'sd48, 8'h00, 8'h00, 8'h00});
    send_pixel('{10'd1, 10'd1023, 16'sd1000, 8'h12, 8'h34, 8'h56});
    wait_idle();
  endtask

  task automatic test_random(int n_sets, int per_set);
    logic signed [31:0] m [16];
    for (int s = 0; s < n_sets; s++) begin
      foreach (m[i]) begin
        case ($urandom_range(0, 3))
          0: m[i] = $urandom;
          1: m[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
          2: m[i] = 0;
          default: m[i] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
      end
      // keep the divisor row well-formed most of the time
      if (s % 3 != 2) begin
        m[12] = 0; m[13] = 0; m[15] = 0;
        m[14] = $urandom_range(1, 32'h0001_0000);
      end
      load_matrix(m);
      long_gaps = (s % 4 != 1);
      stall_enable = (s % 5 != 3);
      for (int i = 0; i < per_set; i++) send_pixel(rand_pixel(1'b1));
      wait_idle();
    end
    long_gaps = 1'b1;
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    test_identity_like();
    test_zero_divisor();
    test_extremes();
    test_random(10, 134);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
